FILE: src/tsss_pkg.sv
// ----------------------------------------------------------------------------
// tsss_pkg
// Shared types and constants of the task slot sleep scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tsss_pkg;

  localparam int OPCODE_W = 3;
  localparam int SEL_W    = 8;
  localparam int SCNT_W   = 16;
  localparam int STAT_W   = 3;
  localparam int RSLOT_W  = 4;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD   = 3'd0,
    OP_KILL  = 3'd1,
    OP_SLEEP = 3'd2,
    OP_TICK  = 3'd3,
    OP_DONE  = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_ADDED     = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_KILLED    = 3'd2,
    STAT_BAD_SLOT  = 3'd3,
    STAT_SLEEP_SET = 3'd4,
    STAT_DISPATCH  = 3'd5,
    STAT_TICK_DONE = 3'd6,
    STAT_MARKED    = 3'd7
  } stat_t;

  typedef enum logic [1:0] {
    MODE_READY    = 2'd0,
    MODE_SLEEPING = 2'd1,
    MODE_DONE     = 2'd2
  } mode_t;

  typedef struct packed {
    logic exec_op;
    logic walk_step;
    logic emit_dispatch;
    logic emit_done;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic slot_ready;
    logic last_slot;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: src/tsss_ram.sv
// ----------------------------------------------------------------------------
// tsss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: src/tsss_ctrl.sv
// ----------------------------------------------------------------------------
// tsss_ctrl
// Controller: takes input beats, sequences the tick walk and the final beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tsss_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [tsss_pkg::OPCODE_W-1:0] opcode,
  input  wire tsss_pkg::dp_sts_t       sts,
  output tsss_pkg::ctl_cmd_t           cmd
);

  import tsss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  logic   is_tick;

  assign is_tick   = (op_t'(opcode) == OP_TICK);
  assign in_tready = (state_r == ST_IDLE) && sts.out_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_tick) begin
            state_nxt = ST_WALK;
          end else begin
            cmd.exec_op = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (sts.slot_ready) begin
          cmd.emit_dispatch = sts.out_free;
          cmd.walk_step     = sts.out_free;
        end else begin
          cmd.walk_step = 1'b1;
        end
        if (cmd.walk_step && sts.last_slot) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_done |=> (state_r == ST_IDLE) && !cmd.emit_done)
    else $error("tick-done beat not followed by idle");

  a_tick_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_tick) |=> (state_r == ST_WALK) && !cmd.emit_done)
    else $error("accepted tick did not start the walk");

endmodule

`default_nettype wire

FILE: src/tsss_dp.sv
// ----------------------------------------------------------------------------
// tsss_dp
// Datapath: slot table, countdown RAM, walk index and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsss_dp #(
  parameter int SLOT_COUNT = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tsss_pkg::ctl_cmd_t            cmd,
  output tsss_pkg::dp_sts_t                  sts,
  input  wire logic [tsss_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [tsss_pkg::SEL_W-1:0]    slot_sel,
  input  wire logic [tsss_pkg::SCNT_W-1:0]   sleep_count,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [tsss_pkg::OUT_W-1:0]         out_tdata,
  output logic                               out_tlast
);

  import tsss_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  mode_t                 mode_r [SLOT_COUNT];
  mode_t                 mode_nxt [SLOT_COUNT];
  logic [IDX_W-1:0]      idx_r, idx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  stat_t                 out_status_r, out_status_nxt;
  logic [RSLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  load;

  logic                  in_range;
  logic [IDX_W-1:0]      sel_idx;
  logic                  sel_ok;
  logic                  full;
  logic [IDX_W-1:0]      free_idx;
  logic [COUNT_BITS-1:0] sat_count;
  logic [31:0]           cnt_ext;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  logic                  cur_active;
  mode_t                 cur_mode;

  assign in_range   = {1'b0, slot_sel} < (SEL_W+1)'(SLOT_COUNT);
  assign sel_idx    = slot_sel[IDX_W-1:0];
  assign sel_ok     = in_range && active_r[sel_idx];
  assign cnt_ext    = 32'(sleep_count);
  assign sat_count  = (cnt_ext > CNT_MAX[31:0]) ? CNT_MAX[COUNT_BITS-1:0]
                                                : cnt_ext[COUNT_BITS-1:0];
  assign cur_active = active_r[idx_r];
  assign cur_mode   = mode_r[idx_r];

  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        full     = 1'b0;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.slot_ready = cur_active && (cur_mode == MODE_READY);
  assign sts.last_slot  = (idx_r == IDX_W'(SLOT_COUNT - 1));

  always_comb begin
    active_nxt     = active_r;
    mode_nxt       = mode_r;
    idx_nxt        = idx_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = ram_rdata - COUNT_BITS'(1);
    load           = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = 1'b1;

    if (cmd.exec_op) begin
      case (op_t'(opcode))
        OP_ADD: begin
          load = 1'b1;
          if (full) begin
            out_status_nxt = STAT_FULL;
            out_slot_nxt   = '0;
          end else begin
            active_nxt[free_idx] = 1'b1;
            mode_nxt[free_idx]   = MODE_READY;
            out_status_nxt       = STAT_ADDED;
            out_slot_nxt         = RSLOT_W'(free_idx);
          end
        end
        OP_KILL: begin
          load = 1'b1;
          if (sel_ok) begin
            active_nxt[sel_idx] = 1'b0;
            mode_nxt[sel_idx]   = MODE_DONE;
            out_status_nxt      = STAT_KILLED;
            out_slot_nxt        = slot_sel[RSLOT_W-1:0];
          end else begin
            out_status_nxt = STAT_BAD_SLOT;
            out_slot_nxt   = '0;
          end
        end
        OP_SLEEP: begin
          load = 1'b1;
          if (sel_ok) begin
            mode_nxt[sel_idx] = MODE_SLEEPING;
            ram_we            = 1'b1;
            ram_waddr         = sel_idx;
            ram_wdata         = sat_count;
            out_status_nxt    = STAT_SLEEP_SET;
            out_slot_nxt      = slot_sel[RSLOT_W-1:0];
          end else begin
            out_status_nxt = STAT_BAD_SLOT;
            out_slot_nxt   = '0;
          end
        end
        OP_DONE: begin
          load = 1'b1;
          if (in_range) begin
            mode_nxt[sel_idx] = MODE_DONE;
            out_status_nxt    = STAT_MARKED;
            out_slot_nxt      = slot_sel[RSLOT_W-1:0];
          end else begin
            out_status_nxt = STAT_BAD_SLOT;
            out_slot_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.walk_step) begin
      if (cur_active) begin
        case (cur_mode)
          MODE_SLEEPING: begin
            if (ram_rdata != '0) begin
              ram_we = 1'b1;
            end else begin
              mode_nxt[idx_r] = MODE_READY;
            end
          end
          MODE_READY: begin
          end
          default: begin
            active_nxt[idx_r] = 1'b0;
          end
        endcase
      end
      idx_nxt = sts.last_slot ? '0 : idx_r + IDX_W'(1);
    end

    if (cmd.emit_dispatch) begin
      load           = 1'b1;
      out_status_nxt = STAT_DISPATCH;
      out_slot_nxt   = RSLOT_W'(idx_r);
      out_last_nxt   = 1'b0;
    end

    if (cmd.emit_done) begin
      load           = 1'b1;
      out_status_nxt = STAT_TICK_DONE;
      out_slot_nxt   = '0;
    end

    if (!load) begin
      out_last_nxt = out_last_r;
    end
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  assign ram_raddr = idx_nxt;

  tsss_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(SLOT_COUNT)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        mode_r[i] <= MODE_DONE;
      end
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_slot_r, out_status_r};
  assign out_tlast  = out_last_r;

  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_step && sts.last_slot) |=> (idx_r == '0))
    else $error("walk index did not return to slot zero");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> sts.out_free)
    else $error("result register overwritten while held");

  a_dispatch_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_dispatch |-> (cur_active && (cur_mode == MODE_READY)))
    else $error("dispatch of a slot that is not ready");

  a_add_claims: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_op && (op_t'(opcode) == OP_ADD) && !full)
      |=> ($countones(active_r) == $past($countones(active_r)) + 1))
    else $error("add did not claim exactly one slot");

endmodule

`default_nettype wire

FILE: src/task_slot_sleep_scheduler.sv
// ----------------------------------------------------------------------------
// task_slot_sleep_scheduler
// Task slot table with add, kill, sleep, mark-done and a tick that walks the
// slots, counts sleepers down, frees done slots and dispatches ready slots.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  in_tdata: opcode, slot_sel, sleep_count
//  out_     out  out_tvalid/out_tready out_tdata: status, result_slot;
//                                     out_tlast: end_of_run
//
//  For add, kill, sleep and mark-done the result beat is registered and
//  shows up the cycle after the input beat.
//  A tick walks one slot per cycle through the countdown RAM read port,
//  bar the stall below, then sends the tick-done beat.
//  A held output beat stalls the walk at the next dispatch and blocks input.
//  Reset leaves every slot inactive and done; the countdown RAM needs no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module task_slot_sleep_scheduler #(
  parameter int SLOT_COUNT = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // [2:0] opcode, [10:3] slot_sel, [26:11] sleep_count, [31:27] zero
  input  wire logic [tsss_pkg::IN_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [2:0] status, [6:3] result_slot, [7] zero
  output logic      [tsss_pkg::OUT_W-1:0]  out_tdata,
  output logic                             out_tlast
);

  import tsss_pkg::*;

  ctl_cmd_t            cmd;
  dp_sts_t             sts;
  logic [OPCODE_W-1:0] opcode;
  logic [SEL_W-1:0]    slot_sel;
  logic [SCNT_W-1:0]   sleep_count;

  assign opcode      = in_tdata[OPCODE_W-1:0];
  assign slot_sel    = in_tdata[OPCODE_W+SEL_W-1:OPCODE_W];
  assign sleep_count = in_tdata[OPCODE_W+SEL_W+SCNT_W-1:OPCODE_W+SEL_W];

  tsss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .opcode   (opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsss_dp #(
    .SLOT_COUNT(SLOT_COUNT),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .slot_sel   (slot_sel),
    .sleep_count(sleep_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
